>>> rtl/core/swhs_pkg.sv
// Shared types and constants for the single-wire humidity sensor reader.
`timescale 1ns / 1ps

package swhs_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LOW  = 2'd1,
		PH_HIGH = 2'd2,
		PH_READ = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		REG_START_LOW  = 3'd0,
		REG_START_HIGH = 3'd1,
		REG_THRESHOLD  = 3'd2,
		REG_TIMEOUT    = 3'd3,
		REG_MAX_TRANS  = 3'd4
	} reg_index_t;

	localparam logic [15:0] START_LOW_RST  = 16'd18000;
	localparam logic [7:0]  START_HIGH_RST = 8'd40;
	localparam logic [7:0]  THRESHOLD_RST  = 8'd16;
	localparam logic [7:0]  TIMEOUT_RST    = 8'd255;
	localparam logic [6:0]  MAX_TRANS_RST  = 7'd85;

	localparam logic [7:0]  LEVEL_MAX      = 8'hFF;
	localparam logic [6:0]  FIRST_DATA_TRANS = 7'd4;

endpackage

>>> rtl/core/single_wire_humidity_sensor_reader.sv
// Top level of the single-wire humidity sensor reader.
`timescale 1ns / 1ps

//  channel  direction  handshake                  payload
//  s_axis   in         s_axis_tvalid/tready       tuser: cmd; tdata: pin_level
//  m_axis   out        m_axis_tvalid/tready       tdata: status, bit count, 4 data bytes
//  cfg      in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// An accepted tick yields a result the next cycle; one tick per clock unless stalled.
// The per-tick update (counters, one shift, a byte checksum) sits between the input
// transfer and the result register; s_axis_tready holds low only while a result waits
// and m_axis_tready is low. Reset puts the reader idle with the register defaults.
// cfg_ready is always high.

module single_wire_humidity_sensor_reader #(
	parameter int FRAME_BYTES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] pin_level, [7:1] zero
	input  logic        s_axis_tuser,  // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] drive_enable, [1] drive_level, [2] busy_res, [3] done_res, [4] timed_out,
	// [5] data_ok, [11:6] bits_received, [19:12] humidity_whole,
	// [27:20] humidity_fraction, [35:28] temperature_whole,
	// [43:36] temperature_fraction, [47:44] zero
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int FRAME_BITS = 8 * FRAME_BYTES;
	localparam int BCW        = $clog2(FRAME_BITS + 1);
	localparam int HIW        = BCW - 3;

	// configuration
	logic [15:0] start_low_q;
	logic [7:0]  start_high_q;
	logic [7:0]  threshold_q;
	logic [7:0]  timeout_q;
	logic [6:0]  max_trans_q;

	// reader state
	swhs_pkg::phase_t ph_q, ph_n;
	logic [15:0]     timer_q, timer_n;
	logic [7:0]      level_q, level_n;
	logic            prev_q, prev_n;
	logic [6:0]      trans_q, trans_n;
	logic [BCW-1:0]  bits_q, bits_n;
	logic [7:0]      bytes_q [FRAME_BYTES];
	logic [7:0]      bytes_n [FRAME_BYTES];

	logic        out_valid_q;
	logic [47:0] out_data_q, out_data_n;

	logic in_xfer;
	logic cmd;
	logic pin;
	logic done;
	logic tout;
	logic ok;
	logic bit_val;
	logic [7:0] sum;
	logic [7:0] shown [4];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cmd           = s_axis_tuser;
	assign pin           = s_axis_tdata[0];
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_q  <= swhs_pkg::START_LOW_RST;
			start_high_q <= swhs_pkg::START_HIGH_RST;
			threshold_q  <= swhs_pkg::THRESHOLD_RST;
			timeout_q    <= swhs_pkg::TIMEOUT_RST;
			max_trans_q  <= swhs_pkg::MAX_TRANS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				swhs_pkg::REG_START_LOW:  start_low_q  <= cfg_data;
				swhs_pkg::REG_START_HIGH: start_high_q <= cfg_data[7:0];
				swhs_pkg::REG_THRESHOLD:  threshold_q  <= cfg_data[7:0];
				swhs_pkg::REG_TIMEOUT:    timeout_q    <= cfg_data[7:0];
				swhs_pkg::REG_MAX_TRANS:  max_trans_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ph_n    = ph_q;
		timer_n = timer_q;
		level_n = level_q;
		prev_n  = prev_q;
		trans_n = trans_q;
		bits_n  = bits_q;
		for (int k = 0; k < FRAME_BYTES; k++) begin
			bytes_n[k] = bytes_q[k];
		end
		done    = 1'b0;
		tout    = 1'b0;
		bit_val = level_q > threshold_q;
		if (cmd) begin
			ph_n    = swhs_pkg::PH_LOW;
			timer_n = '0;
			level_n = '0;
			prev_n  = 1'b1;
			trans_n = '0;
			bits_n  = '0;
			for (int k = 0; k < FRAME_BYTES; k++) begin
				bytes_n[k] = '0;
			end
		end else begin
			case (ph_q)
				swhs_pkg::PH_LOW: begin
					timer_n = timer_q + 16'd1;
					if (timer_n >= start_low_q) begin
						ph_n    = swhs_pkg::PH_HIGH;
						timer_n = '0;
					end
				end
				swhs_pkg::PH_HIGH: begin
					timer_n = timer_q + 16'd1;
					if (timer_n >= {8'd0, start_high_q}) begin
						ph_n    = swhs_pkg::PH_READ;
						timer_n = '0;
					end
				end
				swhs_pkg::PH_READ: begin
					if (pin == prev_q) begin
						// saturate the level count
						if (level_q != swhs_pkg::LEVEL_MAX) begin
							level_n = level_q + 8'd1;
						end
						if (level_n >= timeout_q) begin
							done = 1'b1;
							tout = 1'b1;
						end
					end else begin
						prev_n = pin;
						// shift a bit on even transitions past the preamble; drop overflow
						if (trans_q >= swhs_pkg::FIRST_DATA_TRANS && !trans_q[0]
						    && bits_q < BCW'(FRAME_BITS)) begin
							for (int k = 0; k < FRAME_BYTES; k++) begin
								if (bits_q[BCW-1:3] == HIW'(k)) begin
									bytes_n[k] = {bytes_q[k][6:0], bit_val};
								end
							end
							bits_n = bits_q + BCW'(1);
						end
						level_n = '0;
						trans_n = trans_q + 7'd1;
						if (trans_n >= max_trans_q) begin
							done = 1'b1;
						end
					end
					if (done) begin
						ph_n = swhs_pkg::PH_IDLE;
					end
				end
				default: ;
			endcase
		end

		sum = '0;
		for (int k = 0; k < FRAME_BYTES - 1; k++) begin
			sum = sum + bytes_n[k];
		end
		ok = done && (bits_n >= BCW'(FRAME_BITS)) && (bytes_n[FRAME_BYTES-1] == sum);

		for (int k = 0; k < 4; k++) begin
			shown[k] = (k < FRAME_BYTES) ? bytes_n[k % FRAME_BYTES] : 8'd0;
		end

		out_data_n        = '0;
		out_data_n[0]     = (ph_n == swhs_pkg::PH_LOW) || (ph_n == swhs_pkg::PH_HIGH);
		out_data_n[1]     = ph_n == swhs_pkg::PH_HIGH;
		out_data_n[2]     = ph_n != swhs_pkg::PH_IDLE;
		out_data_n[3]     = done;
		out_data_n[4]     = tout;
		out_data_n[5]     = ok;
		out_data_n[11:6]  = 6'(bits_n);
		out_data_n[19:12] = shown[0];
		out_data_n[27:20] = shown[1];
		out_data_n[35:28] = shown[2];
		out_data_n[43:36] = shown[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= swhs_pkg::PH_IDLE;
			timer_q <= '0;
			level_q <= '0;
			prev_q  <= 1'b1;
			trans_q <= '0;
			bits_q  <= '0;
			for (int k = 0; k < FRAME_BYTES; k++) begin
				bytes_q[k] <= '0;
			end
		end else if (in_xfer) begin
			ph_q    <= ph_n;
			timer_q <= timer_n;
			level_q <= level_n;
			prev_q  <= prev_n;
			trans_q <= trans_n;
			bits_q  <= bits_n;
			for (int k = 0; k < FRAME_BYTES; k++) begin
				bytes_q[k] <= bytes_n[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_data_q <= out_data_n;
		end
	end

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q[3] |-> !out_data_q[2])
		else $error("done reported while still busy");

	a_tout_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_data_q[4] || out_data_q[5]) |-> out_data_q[3])
		else $error("timeout or data_ok without done");

	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= BCW'(FRAME_BITS))
		else $error("bit count past frame length");

	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_xfer |=> $stable(ph_q) && $stable(bits_q))
		else $error("reader state moved without an input transfer");

endmodule
